// ===== src/decimating_moving_average_defines.svh =====
// Assertion macros for the decimating moving average block.
`ifndef DECIMATING_MOVING_AVERAGE_DEFINES_SVH
`define DECIMATING_MOVING_AVERAGE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, disabled while reset is asserted (active low).
`define DMA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked property, also evaluated during reset.
`define DMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DMA_ASSERT(lbl, clk, rst_n, prop, msg)
`define DMA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/dma_pkg.sv =====
// Shared types and constants for the decimating moving average block.
package dma_pkg;

  localparam int unsigned SAMPLE_W      = 12;
  localparam int unsigned WINDOW_W      = 5;
  localparam int unsigned PHASE_W       = 4;
  localparam int unsigned MAX_WINDOW    = 16;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(8);
  localparam logic [PHASE_W-1:0]  DECIMATION   = PHASE_W'(10);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// ===== src/decimating_moving_average.sv =====
// Decimating moving average: top level with delay line, sequencer and serial divider.
//
//  channel   dir  handshake              payload
//  -------   ---  ---------------------  ------------------------
//  input     in   in_valid_i/in_stall_o  sample_i [11:0]
//  output    out  out_valid_o/out_stall_i average_o [11:0]
//  config    in   cfg_valid_i/cfg_ready_o window_length_i [4:0]
//
// A sample that does not complete a decimation period only shifts the delay line and advances the phase.
// Every tenth sample starts the sequencer: accumulation of W samples through one
// adder (W = effective window), then restoring division of the SW = 12 +
// clog2(MAX_WINDOW) bit sum, one quotient bit a cycle, then the load of the
// output register.
// Reset clears the delay line, the phase counter and the window (to 8).
// in_stall_o is high while the sequencer runs; a waiting result only holds
// the sequencer in its last step, the delay line keeps taking samples after.
`include "decimating_moving_average_defines.svh"

module decimating_moving_average #(
  parameter int unsigned MAX_WINDOW = dma_pkg::MAX_WINDOW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input sample transactions
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dma_pkg::SAMPLE_W-1:0]  sample_i,
  // result transactions
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dma_pkg::SAMPLE_W-1:0]  average_o,
  // window length register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dma_pkg::WINDOW_W-1:0]  window_length_i
);

  // index into the delay line
  localparam int unsigned IW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  // effective window value 1..MAX_WINDOW
  localparam int unsigned WW  = $clog2(MAX_WINDOW + 1);
  // sum of up to MAX_WINDOW samples, also the quotient shift register
  localparam int unsigned SW  = dma_pkg::SAMPLE_W + IW;
  localparam int unsigned DCW = $clog2(SW);

  dma_pkg::state_e state_q, state_d;

  logic [dma_pkg::SAMPLE_W-1:0] line_q [MAX_WINDOW];
  logic [dma_pkg::PHASE_W-1:0]  phase_q;
  logic [dma_pkg::WINDOW_W-1:0] window_q;
  logic [WW-1:0]                w_eff;

  logic [IW-1:0]                idx_q;
  logic [DCW-1:0]               div_cnt_q;
  logic [SW-1:0]                acc_q;
  logic [WW-1:0]                rem_q;

  logic                         out_valid_q;
  logic [dma_pkg::SAMPLE_W-1:0] average_q;

  logic                         in_acc;
  logic                         period_end;
  logic                         sum_last;
  logic                         out_free;
  logic                         out_load;
  logic [dma_pkg::PHASE_W-1:0]  phase_inc;

  // restoring divider step
  logic [WW:0]                  div_pair;
  logic [WW:0]                  div_diff;
  logic                         div_ge;

  // Window clamp: zero acts as one, anything above the line depth saturates.
  always_comb begin
    if (window_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(window_q) > MAX_WINDOW) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = WW'(window_q);
    end
  end

  // window only changes while the sequencer is idle, so w_eff is stable per average
  assign cfg_ready_o = (state_q == dma_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= dma_pkg::WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_q <= window_length_i;
    end
  end

  assign in_stall_o = (state_q != dma_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign phase_inc  = phase_q + dma_pkg::PHASE_W'(1);
  assign period_end = (phase_inc >= dma_pkg::DECIMATION);
  assign sum_last   = (WW'(idx_q) == (w_eff - WW'(1)));
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dma_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      dma_pkg::ST_IDLE: begin
        if (in_acc && period_end) begin
          state_d = dma_pkg::ST_SUM;
        end
      end
      dma_pkg::ST_SUM: begin
        if (sum_last) begin
          state_d = dma_pkg::ST_DIV;
        end
      end
      dma_pkg::ST_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = dma_pkg::ST_OUT;
        end
      end
      dma_pkg::ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = dma_pkg::ST_IDLE;
        end
      end
      default: state_d = dma_pkg::ST_IDLE;
    endcase
  end

  // Delay line: only the newest w_eff positions move.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        line_q[i] <= '0;
      end
    end else if (in_acc) begin
      line_q[0] <= sample_i;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        if (32'(w_eff) > i) begin
          line_q[i] <= line_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (in_acc) begin
      phase_q <= period_end ? '0 : phase_inc;
    end
  end

  // Restoring division: shift the next dividend bit into the remainder.
  assign div_pair = {rem_q, acc_q[SW-1]};
  assign div_diff = div_pair - {1'b0, w_eff};
  assign div_ge   = (div_pair >= {1'b0, w_eff});

  // Accumulator / quotient datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      dma_pkg::ST_IDLE: begin
        acc_q <= '0;
        idx_q <= '0;
      end
      dma_pkg::ST_SUM: begin
        acc_q     <= acc_q + SW'(line_q[idx_q]);
        idx_q     <= idx_q + IW'(1);
        rem_q     <= '0;
        div_cnt_q <= DCW'(SW - 1);
      end
      dma_pkg::ST_DIV: begin
        div_cnt_q <= div_cnt_q - DCW'(1);
        if (div_ge) begin
          rem_q <= div_diff[WW-1:0];
          acc_q <= {acc_q[SW-2:0], 1'b1};
        end else begin
          rem_q <= div_pair[WW-1:0];
          acc_q <= {acc_q[SW-2:0], 1'b0};
        end
      end
      dma_pkg::ST_OUT: begin
        acc_q <= acc_q;
      end
      default: acc_q <= acc_q;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      average_q <= acc_q[dma_pkg::SAMPLE_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;

  // Assertions
  `DMA_ASSERT(a_phase_range, clk_i, rst_ni, phase_q < dma_pkg::DECIMATION, "phase out of range")
  `DMA_ASSERT(a_quiet_sample, clk_i, rst_ni, in_acc && !period_end |=> state_q == dma_pkg::ST_IDLE, "sequencer started early")
  `DMA_ASSERT(a_rem_bound, clk_i, rst_ni, state_q == dma_pkg::ST_DIV |-> rem_q < w_eff, "remainder not below divisor")
  `DMA_ASSERT(a_result_src, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q) == dma_pkg::ST_OUT, "result without division")
  `DMA_ASSERT(a_no_overwrite, clk_i, rst_ni, out_load |-> out_free, "pending result overwritten")

endmodule
